>>> rtl/t1bpc_pkg.sv
// Shared types, codes and constants of the T=1 block protocol controller.
// Used by the decision core, the top level and the port checker.
`timescale 1ns / 1ps

package t1bpc_pkg;

    // Fixed field widths.
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned EXCH_W = 7;
    localparam int unsigned STAT_W = 4;
    localparam int unsigned SRC_W  = 2;

    // Defaults for the top-level parameters.
    localparam int unsigned MAX_APDU_DEF       = 4096;
    localparam int unsigned INF_MAX_DEF        = 254;
    localparam int unsigned EXCHANGE_LIMIT_DEF = 64;

    // Configuration register reset value and lower clamp.
    localparam logic [BYTE_W-1:0] IFSC_RESET = 8'd32;
    localparam logic [BYTE_W-1:0] IFSC_MIN   = 8'd16;

    // Configuration register index.
    localparam logic REG_IFSC = 1'b0;

    // Input function codes.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_RX    = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_SEND        = 4'd0;
    localparam logic [STAT_W-1:0] ST_DONE        = 4'd1;
    localparam logic [STAT_W-1:0] ST_XFAIL       = 4'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW    = 4'd3;
    localparam logic [STAT_W-1:0] ST_CARD_ERR    = 4'd4;
    localparam logic [STAT_W-1:0] ST_STRAY_R     = 4'd5;
    localparam logic [STAT_W-1:0] ST_STRAY_S     = 4'd6;
    localparam logic [STAT_W-1:0] ST_NO_CONVERGE = 4'd7;
    localparam logic [STAT_W-1:0] ST_IGNORED     = 4'd8;

    // Payload source codes.
    localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
    localparam logic [SRC_W-1:0] SRC_APDU = 2'd1;
    localparam logic [SRC_W-1:0] SRC_ECHO = 2'd2;

    // PCB bit masks.
    localparam logic [BYTE_W-1:0] PCB_MORE     = 8'h20;
    localparam logic [BYTE_W-1:0] PCB_R_BLOCK  = 8'h80;
    localparam logic [BYTE_W-1:0] PCB_TYPE     = 8'hC0;
    localparam logic [BYTE_W-1:0] PCB_ERR_BITS = 8'h0F;

    localparam logic [EXCH_W-1:0] EXCH_SAT = 7'h7F;

    typedef struct packed {
        logic              func;
        logic [LEN_W-1:0]  cmd_len;
        logic [LEN_W-1:0]  rsp_cap;
        logic [BYTE_W-1:0] rx_pcb;
        logic [BYTE_W-1:0] rx_len;
        logic              rx_ok;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] tx_pcb;
        logic [SRC_W-1:0]  tx_source;
        logic [LEN_W-1:0]  tx_offset;
        logic [BYTE_W-1:0] tx_len;
        logic [LEN_W-1:0]  resp_offset;
        logic [BYTE_W-1:0] resp_append;
        logic [LEN_W-1:0]  resp_total;
    } t_result;

    typedef struct packed {
        logic              send_seq;
        logic [LEN_W-1:0]  sent_count;
        logic [LEN_W-1:0]  resp_count;
        logic [EXCH_W-1:0] exchange_count;
        logic [BYTE_W-1:0] last_tx_pcb;
        logic [BYTE_W-1:0] last_tx_len;
        logic              busy;
        logic [LEN_W-1:0]  apdu_length;
        logic [LEN_W-1:0]  resp_limit;
    } t_state;

endpackage

>>> rtl/t1_block_protocol_controller.sv
// Top level of the host-side T=1 block controller: channel registers, state,
// the IFSC register and its APB port. Depends on t1bpc_pkg and t1bpc_core.
`timescale 1ns / 1ps

// Usage
// The input channel (i_in_valid / o_in_stall) carries one item per transfer: a
// start of a new APDU transaction or the report of a block received from the card.
// The output channel (o_out_valid / i_out_stall) carries exactly one result per
// item, in order: the next block to send, or the end of the transaction.
// An item is held in an input register, decided combinationally by the core, and its
// result lands in an output register together with the state update. o_out_valid
// rises once the result is in the output register; one item per cycle is sustained
// while the receiver does not stall, since the next state is registered together
// with each result.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; the sender sees o_in_stall only while both registers
// are full and the receiver keeps stalling.
// Synchronous reset empties the channel registers, clears the transaction state, marks
// the block idle and sets IFSC to 32. IFSC is written over the APB port at byte
// address 0 and should only change while no transfer is in flight.

module t1_block_protocol_controller #(
    parameter int unsigned MAX_APDU       = t1bpc_pkg::MAX_APDU_DEF,
    parameter int unsigned INF_MAX        = t1bpc_pkg::INF_MAX_DEF,
    parameter int unsigned EXCHANGE_LIMIT = t1bpc_pkg::EXCHANGE_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [12:0] i_cmd_len,
    input  logic [12:0] i_rsp_cap,
    input  logic [7:0]  i_rx_pcb,
    input  logic [7:0]  i_rx_len,
    input  logic        i_rx_ok,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_status,
    output logic [7:0]  o_tx_pcb,
    output logic [1:0]  o_tx_source,
    output logic [12:0] o_tx_offset,
    output logic [7:0]  o_tx_len,
    output logic [12:0] o_resp_offset,
    output logic [7:0]  o_resp_append,
    output logic [12:0] o_resp_total
);
    import t1bpc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    logic [BYTE_W-1:0] r_ifsc;

    t_state  n_state;
    t_result n_out;

    logic w_in_accept;
    logic w_advance;
    logic w_cfg_write;

    // The held item moves on when the output register is empty or being drained.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_IFSC) ? {24'b0, r_ifsc} : 32'b0;

    t1bpc_core #(
        .MAX_APDU       (MAX_APDU),
        .INF_MAX        (INF_MAX),
        .EXCHANGE_LIMIT (EXCHANGE_LIMIT)
    ) u_core (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_ifsc   (r_ifsc),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Control state, transaction state and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_ifsc      <= IFSC_RESET;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_write && paddr[2] == REG_IFSC) begin
                r_ifsc <= pwdata[BYTE_W-1:0];
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in <= '{func: i_func, cmd_len: i_cmd_len, rsp_cap: i_rsp_cap,
                      rx_pcb: i_rx_pcb, rx_len: i_rx_len, rx_ok: i_rx_ok};
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_tx_pcb      = r_out.tx_pcb;
    assign o_tx_source   = r_out.tx_source;
    assign o_tx_offset   = r_out.tx_offset;
    assign o_tx_len      = r_out.tx_len;
    assign o_resp_offset = r_out.resp_offset;
    assign o_resp_append = r_out.resp_append;
    assign o_resp_total  = r_out.resp_total;

endmodule

>>> rtl/t1bpc_core.sv
// Decision logic of the T=1 block controller: one item and the current state in,
// the result and the next state out. Depends on t1bpc_pkg.
`timescale 1ns / 1ps

module t1bpc_core #(
    parameter int unsigned MAX_APDU       = t1bpc_pkg::MAX_APDU_DEF,
    parameter int unsigned INF_MAX        = t1bpc_pkg::INF_MAX_DEF,
    parameter int unsigned EXCHANGE_LIMIT = t1bpc_pkg::EXCHANGE_LIMIT_DEF
) (
    input  t1bpc_pkg::t_item   i_item,
    input  t1bpc_pkg::t_state  i_state,
    input  logic [7:0]         i_ifsc,
    output t1bpc_pkg::t_state  o_state,
    output t1bpc_pkg::t_result o_result
);
    import t1bpc_pkg::*;

    localparam logic [BYTE_W-1:0] InfMax   = BYTE_W'(INF_MAX);
    localparam logic [EXCH_W-1:0] ExchLim  = EXCH_W'(EXCHANGE_LIMIT);
    localparam logic [LEN_W-1:0]  ApduSat  = LEN_W'(MAX_APDU);

    // Slice of the APDU that starts at sent, at most lim bytes long.
    function automatic logic [2*BYTE_W-1:0] slice(input logic [LEN_W-1:0] apdu,
                                                  input logic [LEN_W-1:0] sent,
                                                  input logic seq,
                                                  input logic [BYTE_W-1:0] lim);
        logic [LEN_W-1:0]  rem;
        logic              more;
        logic [BYTE_W-1:0] len;
        rem  = (apdu > sent) ? (apdu - sent) : '0;
        more = rem > {{(LEN_W-BYTE_W){1'b0}}, lim};
        len  = more ? lim : rem[BYTE_W-1:0];
        return {1'b0, seq, more, 5'b0, len};
    endfunction

    logic [BYTE_W-1:0] w_lim;
    logic [BYTE_W-1:0] w_rlen;
    logic [LEN_W-1:0]  w_apdu_sat;
    logic [LEN_W-1:0]  w_resp_sat;
    logic [LEN_W:0]    w_resp_sum;
    logic [2*BYTE_W-1:0] w_slice;

    always_comb begin
        w_lim = i_ifsc;
        if (w_lim < IFSC_MIN) begin
            w_lim = IFSC_MIN;
        end
        if (w_lim > InfMax) begin
            w_lim = InfMax;
        end
        w_rlen     = (i_item.rx_len > InfMax) ? InfMax : i_item.rx_len;
        w_apdu_sat = (32'(i_item.cmd_len) > 32'(MAX_APDU)) ? ApduSat : i_item.cmd_len;
        w_resp_sat = (32'(i_item.rsp_cap) > 32'(MAX_APDU)) ? ApduSat : i_item.rsp_cap;
        w_resp_sum = {1'b0, i_state.resp_count} + {{(LEN_W+1-BYTE_W){1'b0}}, w_rlen};
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        w_slice  = '0;

        if (i_item.func == FUNC_START) begin
            // A start drops any running transaction; the sequence bit carries over.
            w_slice                = slice(w_apdu_sat, '0, i_state.send_seq, w_lim);
            o_state.apdu_length    = w_apdu_sat;
            o_state.resp_limit     = w_resp_sat;
            o_state.sent_count     = '0;
            o_state.resp_count     = '0;
            o_state.exchange_count = '0;
            o_state.busy           = 1'b1;
            o_state.last_tx_pcb    = w_slice[2*BYTE_W-1:BYTE_W];
            o_state.last_tx_len    = w_slice[BYTE_W-1:0];
            o_result.status        = ST_SEND;
            o_result.tx_pcb        = w_slice[2*BYTE_W-1:BYTE_W];
            o_result.tx_source     = SRC_APDU;
            o_result.tx_len        = w_slice[BYTE_W-1:0];
        end else if (!i_state.busy) begin
            o_result.status = ST_IGNORED;
        end else begin
            if (i_state.exchange_count != EXCH_SAT) begin
                o_state.exchange_count = i_state.exchange_count + 1'b1;
            end
            o_result.resp_offset = i_state.resp_count;
            o_result.status      = ST_SEND;

            if (!i_item.rx_ok) begin
                o_result.status = ST_XFAIL;
            end else begin
                // The card answered, so an I-block we sent counts as delivered.
                if ((i_state.last_tx_pcb & PCB_R_BLOCK) == '0) begin
                    o_state.send_seq   = ~i_state.send_seq;
                    o_state.sent_count = i_state.sent_count
                                         + {{(LEN_W-BYTE_W){1'b0}}, i_state.last_tx_len};
                end
                if ((i_item.rx_pcb & PCB_R_BLOCK) == '0) begin
                    // I-block from the card.
                    if (w_resp_sum > {1'b0, i_state.resp_limit}) begin
                        o_result.status = ST_OVERFLOW;
                    end else begin
                        o_result.resp_append = w_rlen;
                        o_state.resp_count   = w_resp_sum[LEN_W-1:0];
                        if ((i_item.rx_pcb & PCB_MORE) == '0) begin
                            o_result.status = ST_DONE;
                        end else begin
                            // Acknowledge card chaining with the next expected number.
                            o_result.tx_pcb    = PCB_R_BLOCK | {3'b0, ~i_item.rx_pcb[6], 4'b0};
                            o_result.tx_source = SRC_NONE;
                        end
                    end
                end else if ((i_item.rx_pcb & PCB_TYPE) == PCB_R_BLOCK) begin
                    // R-block from the card.
                    if ((i_item.rx_pcb & PCB_ERR_BITS) != '0) begin
                        o_result.status = ST_CARD_ERR;
                    end else if (o_state.sent_count >= i_state.apdu_length) begin
                        o_result.status = ST_STRAY_R;
                    end else begin
                        w_slice = slice(i_state.apdu_length, o_state.sent_count,
                                        o_state.send_seq, w_lim);
                        o_result.tx_pcb    = w_slice[2*BYTE_W-1:BYTE_W];
                        o_result.tx_len    = w_slice[BYTE_W-1:0];
                        o_result.tx_offset = o_state.sent_count;
                        o_result.tx_source = SRC_APDU;
                    end
                end else if ((i_item.rx_pcb & PCB_MORE) != '0) begin
                    o_result.status = ST_STRAY_S;
                end else begin
                    // S-block request: answer it and echo its INF.
                    o_result.tx_pcb    = i_item.rx_pcb | PCB_MORE;
                    o_result.tx_source = SRC_ECHO;
                    o_result.tx_len    = w_rlen;
                end
            end

            if (o_result.status == ST_SEND && o_state.exchange_count >= ExchLim) begin
                o_result.status = ST_NO_CONVERGE;
            end
            if (o_result.status == ST_SEND) begin
                o_state.last_tx_pcb = o_result.tx_pcb;
                o_state.last_tx_len = o_result.tx_len;
            end else begin
                o_state.busy       = 1'b0;
                o_result.tx_pcb    = '0;
                o_result.tx_source = SRC_NONE;
                o_result.tx_offset = '0;
                o_result.tx_len    = '0;
            end
            o_result.resp_total = o_state.resp_count;
        end
    end

endmodule

>>> rtl/t1bpc_checker.sv
// Port-level checker of the T=1 block controller and its bind to the top level.
// Depends on t1bpc_pkg.
`timescale 1ns / 1ps

module t1bpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_status,
    input logic [7:0]  o_tx_pcb,
    input logic [1:0]  o_tx_source,
    input logic [12:0] o_tx_offset,
    input logic [7:0]  o_tx_len,
    input logic [12:0] o_resp_offset,
    input logic [7:0]  o_resp_append,
    input logic [12:0] o_resp_total
);
    import t1bpc_pkg::*;

    // A result that ends or ignores a transaction carries no block to send.
    a_no_block_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_SEND) |->
        (o_tx_pcb == '0 && o_tx_source == SRC_NONE && o_tx_offset == '0 && o_tx_len == '0))
        else $error("block fields set on a result that is not a send");

    // Only an APDU slice has an offset into the APDU.
    a_offset_only_slice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_tx_source != SRC_APDU) |-> (o_tx_offset == '0))
        else $error("tx offset set without an APDU slice");

    // The response count after an item is the count before it plus its append.
    a_resp_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_resp_total == 13'(o_resp_offset + 13'(o_resp_append))))
        else $error("response total does not match offset plus append");

    // A stalled result stays offered and unchanged.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_resp_total) && $stable(o_tx_pcb)))
        else $error("stalled result changed");

    // Reset empties the output channel.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule

bind t1_block_protocol_controller t1bpc_checker u_t1bpc_checker (.*);
